### hdl/bce_pkg.sv
// Package for the bitmap color expander: widths, register indexes, lane count
// and the per-byte work word passed from the lane stage to the merge stage.
// No dependencies.
package bce_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int LANES       = 8;
    localparam int DIM_W       = 13;
    localparam int ROW_W       = 13;
    localparam int BYTE_W      = 10;
    localparam int RB_W        = 11;
    localparam int ORG_W       = 16;
    localparam int POS_W       = 17;
    localparam int PIX_W       = 12;
    localparam int ADDR_W      = 24;
    localparam int COLOR_W     = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR = 2'd2;

    typedef struct packed {
        logic [LANES-1:0]            hits;
        logic [LANES-1:0][DIM_W-1:0] fx;
        logic [DIM_W-1:0]            fy;
        logic [ADDR_W-1:0]           row_base;
    } t_byte_work;

endpackage

### hdl/bce_lane.sv
// One column lane: forms the framebuffer x of one mask bit and tests it.
// Depends on bce_pkg.
module bce_lane
    import bce_pkg::*;
(
    input  logic                    i_bit,
    input  logic [DIM_W-1:0]        i_col,
    input  logic signed [ORG_W-1:0] i_origin_x,
    input  logic [DIM_W-1:0]        i_bmp_w,
    input  logic [DIM_W-1:0]        i_fb_w,
    output logic                    o_hit,
    output logic [DIM_W-1:0]        o_fx
);

    logic signed [POS_W-1:0] fx;

    always_comb begin
        fx    = POS_W'(i_origin_x) + $signed({{(POS_W-DIM_W){1'b0}}, i_col});
        o_fx  = fx[DIM_W-1:0];
        o_hit = i_bit && (i_col < i_bmp_w) && !fx[POS_W-1]
                && (fx < $signed({{(POS_W-DIM_W){1'b0}}, i_fb_w}));
    end

endmodule

### hdl/bce_merge.sv
// Merge stage (uses bce_pkg): holds one byte's lane results and issues its hits
// in column order into the output register, one pixel word per unstalled cycle.
module bce_merge
    import bce_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_work_valid,
    input  t_byte_work         i_work,
    output logic               o_work_ready,
    input  logic [COLOR_W-1:0] i_color,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PIX_W-1:0]   o_pixel_x,
    output logic [PIX_W-1:0]   o_pixel_y,
    output logic [ADDR_W-1:0]  o_pixel_address,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last_of_byte
);

    logic             r_m_valid;
    t_byte_work       r_m;
    logic [LANES-1:0] sel;
    logic [LANES-1:0] rest;
    logic [DIM_W-1:0] sel_fx;
    logic             found;
    logic             out_free;
    logic             emit;
    logic             m_done;
    logic             load;

    logic               r_o_valid;
    logic [PIX_W-1:0]   r_x;
    logic [PIX_W-1:0]   r_y;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_last;

    always_comb begin
        sel    = '0;
        sel_fx = '0;
        found  = 1'b0;
        for (int b = 0; b < LANES; b++) begin
            if (r_m.hits[b] && !found) begin
                sel[b] = 1'b1;
                sel_fx = r_m.fx[b];
                found  = 1'b1;
            end
        end
        rest         = r_m.hits & ~sel;
        out_free     = !r_o_valid || !i_stall;
        emit         = r_m_valid && found && out_free;
        m_done       = r_m_valid && (!found || (emit && (rest == '0)));
        load         = !r_m_valid || m_done;
        o_work_ready = load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= i_work_valid;
        end
        if (load) begin
            r_m <= i_work;
        end else if (emit) begin
            r_m.hits <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= emit;
        end
        if (emit) begin
            r_x    <= sel_fx[PIX_W-1:0];
            r_y    <= r_m.fy[PIX_W-1:0];
            r_addr <= r_m.row_base + ADDR_W'(sel_fx);
            r_last <= (rest == '0);
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pixel_x       = r_x;
    assign o_pixel_y       = r_y;
    assign o_pixel_address = r_addr;
    assign o_pixel_color   = i_color;
    assign o_last_of_byte  = r_last;

endmodule

### hdl/bitmap_color_expand.sv
// Top level of the bitmap color expander: config registers, row/byte counters,
// row stage, eight column lanes with the row-base multiply, and the merge stage.
// Depends on bce_pkg, bce_lane, bce_merge.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  mask in  | i_valid / o_stall   | origin_x/y, bitmap_width/height, mask, enable
//  pixel out| o_valid / i_stall   | pixel_x/y, pixel_address, pixel_color, last
//  config   | i_cfg_we            | i_cfg_index, i_cfg_data
//
// A mask word is taken every cycle when downstream keeps up; a word yields
// 0 to 8 pixel words, one per cycle from the merge stage while i_stall is low.
// Path from accept: stage 1, stage 2, merge hold and output registers.
// Reset is synchronous: counters zero, fb 256x256, color 0, pipeline empty.
// Stall on the output holds the pixel word and backs up the row and lane stages.
module bitmap_color_expand
    import bce_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [ORG_W-1:0] i_origin_x,
    input  logic signed [ORG_W-1:0] i_origin_y,
    input  logic [DIM_W-1:0]        i_bitmap_width,
    input  logic [DIM_W-1:0]        i_bitmap_height,
    input  logic [7:0]              i_mask_byte,
    input  logic                    i_draw_enable,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [PIX_W-1:0]        o_pixel_x,
    output logic [PIX_W-1:0]        o_pixel_y,
    output logic [ADDR_W-1:0]       o_pixel_address,
    output logic [COLOR_W-1:0]      o_pixel_color,
    output logic                    o_last_of_byte,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [COLOR_W-1:0]      i_cfg_data
);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (int'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
    endfunction

    logic [DIM_W-1:0]   r_fb_w;
    logic [DIM_W-1:0]   r_fb_h;
    logic [COLOR_W-1:0] r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_w  <= DIM_W'(256);
            r_fb_h  <= DIM_W'(256);
            r_color <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FB_WIDTH:   r_fb_w  <= i_cfg_data[DIM_W-1:0];
                REG_FB_HEIGHT:  r_fb_h  <= i_cfg_data[DIM_W-1:0];
                REG_DRAW_COLOR: r_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
    assign fw = clamp_dim(r_fb_w);
    assign fh = clamp_dim(r_fb_h);

    // row stage inputs
    logic                    accept;
    logic [DIM_W-1:0]        bw;
    logic [DIM_W-1:0]        bh;
    logic [RB_W-1:0]         bytes_per_row;
    logic [RB_W-1:0]         bi_inc;
    logic [ROW_W:0]          row_inc;
    logic signed [POS_W-1:0] fy;
    logic                    row_ok;
    logic [BYTE_W-1:0]       r_byte_in_row;
    logic [ROW_W-1:0]        r_stored_row;
    logic [BYTE_W-1:0]       n_byte_in_row;
    logic [ROW_W-1:0]        n_stored_row;

    always_comb begin
        bw        = clamp_dim(i_bitmap_width);
        bh        = clamp_dim(i_bitmap_height);
        bytes_per_row = RB_W'((DIM_W+1)'(bw) + (DIM_W+1)'(7) >> 3);
        bi_inc    = RB_W'(r_byte_in_row) + RB_W'(1);
        row_inc   = (ROW_W+1)'(r_stored_row) + (ROW_W+1)'(1);
        fy        = POS_W'(i_origin_y)
                    - $signed(POS_W'(bh) - POS_W'(1) - POS_W'(r_stored_row));
        row_ok    = i_draw_enable && (bw != '0) && (bh != '0)
                    && (ROW_W'(r_stored_row) < bh) && !fy[POS_W-1]
                    && (fy < $signed(POS_W'(fh)));
        n_byte_in_row = r_byte_in_row;
        n_stored_row  = r_stored_row;
        if ((bw == '0) || (bh == '0)) begin
            n_byte_in_row = '0;
            n_stored_row  = '0;
        end else if (bi_inc >= bytes_per_row) begin
            n_byte_in_row = '0;
            n_stored_row  = (row_inc >= (ROW_W+1)'(bh)) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_byte_in_row = bi_inc[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_in_row <= '0;
            r_stored_row  <= '0;
        end else if (accept) begin
            r_byte_in_row <= n_byte_in_row;
            r_stored_row  <= n_stored_row;
        end
    end

    // stage 1: row result
    logic                    r1_valid;
    logic                    r1_row_ok;
    logic [DIM_W-1:0]        r1_fy;
    logic signed [ORG_W-1:0] r1_ox;
    logic [DIM_W-1:0]        r1_col;
    logic [7:0]              r1_mask;
    logic [DIM_W-1:0]        r1_bw;
    logic                    s1_load;
    logic                    s2_load;
    logic                    merge_ready;

    assign s1_load = !r1_valid || s2_load;
    assign o_stall = !s1_load;
    assign accept  = i_valid && s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_load) begin
            r1_valid <= i_valid;
        end
        if (accept) begin
            r1_row_ok <= row_ok;
            r1_fy     <= fy[DIM_W-1:0];
            r1_ox     <= i_origin_x;
            r1_col    <= {r_byte_in_row, 3'b000};
            r1_mask   <= i_mask_byte;
            r1_bw     <= bw;
        end
    end

    // stage 2: column lanes and row base
    logic [LANES-1:0]            lane_hit;
    logic [LANES-1:0][DIM_W-1:0] lane_fx;
    logic                        r2_valid;
    t_byte_work                  r2_work;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bce_lane u_lane (
            .i_bit      (r1_mask[LANES-1-g]),
            .i_col      (r1_col + DIM_W'(g)),
            .i_origin_x (r1_ox),
            .i_bmp_w    (r1_bw),
            .i_fb_w     (fw),
            .o_hit      (lane_hit[g]),
            .o_fx       (lane_fx[g])
        );
    end

    assign s2_load = !r2_valid || merge_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_load) begin
            r2_valid <= r1_valid;
        end
        if (s2_load && r1_valid) begin
            r2_work.hits     <= r1_row_ok ? lane_hit : '0;
            r2_work.fx       <= lane_fx;
            r2_work.fy       <= r1_fy;
            r2_work.row_base <= ADDR_W'(r1_fy) * ADDR_W'(fw);
        end
    end

    bce_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_work_valid    (r2_valid),
        .i_work          (r2_work),
        .o_work_ready    (merge_ready),
        .i_color         (r_color),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_of_byte  (o_last_of_byte)
    );

endmodule
